// File: sv/lc2k_pkg.sv
// Shared constants, codes and control structs for the LC-2K executor.
package lc2k_pkg;

  // Word memory depth; must be a power of two, 256 to 65536
  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 144;

  // Request commands
  localparam logic [1:0] CMD_MEM_WR = 2'd0;
  localparam logic [1:0] CMD_MEM_RD = 2'd1;
  localparam logic [1:0] CMD_EXEC   = 2'd2;
  localparam logic [1:0] CMD_REG_RD = 2'd3;

  // Instruction opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NAND = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_JALR = 3'd5;
  localparam logic [2:0] OP_HALT = 3'd6;
  localparam logic [2:0] OP_NOOP = 3'd7;

  // Memory port operations
  localparam logic [2:0] MOP_NONE  = 3'd0;
  localparam logic [2:0] MOP_WR_IN = 3'd1;
  localparam logic [2:0] MOP_RD_IN = 3'd2;
  localparam logic [2:0] MOP_FETCH = 3'd3;
  localparam logic [2:0] MOP_RD_LS = 3'd4;
  localparam logic [2:0] MOP_WR_SW = 3'd5;

  typedef struct packed {
    logic       clr_step;
    logic       take_in;
    logic [2:0] mem_op;
    logic       decode;
    logic       cap_mem;
    logic       cap_reg;
    logic       exec;
    logic       load_wb;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       halted;
    logic [2:0] opcode;
  } dp_stat_t;

endpackage

// File: sv/lc2k_instruction_executor.sv
// Top level: LC-2K executor with stream request and result channels.
//
//  channel  ports        direction  payload
//  request  in_t*        in         tuser: command; tdata: word_address, write_word, reg_select
//  result   out_t*       out        tdata: read_data .. mem_write_value (one per request)
//
// Requests are sequenced through the single memory port (fetch, then data
// access) and the register file read; an instruction while halted skips both.
// After reset the memory is cleared one word a cycle, with in_tready low
// throughout. A result waiting in the output register does not block
// acceptance of the next request.
module lc2k_instruction_executor import lc2k_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // word_address, write_word, reg_select, pad
  input  logic [1:0]             in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // read_data, pc_value, halted, executed_opcode,
                                             // reg_write_valid, reg_write_index,
                                             // reg_write_value, mem_write_valid,
                                             // mem_write_address, mem_write_value, pad
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     deliver;
  logic     out_free;
  logic     req_ready;

  logic [31:0] read_data;
  logic [15:0] pc_value;
  logic        halted;
  logic [2:0]  executed_opcode;
  logic        reg_write_valid;
  logic [2:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        mem_write_valid;
  logic [15:0] mem_write_address;
  logic [31:0] mem_write_value;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = req_ready;

  lc2k_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_command (in_tuser),
    .out_free    (out_free),
    .stat        (stat),
    .req_ready   (req_ready),
    .deliver     (deliver),
    .cmd         (cmd)
  );

  lc2k_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_word_address   (in_tdata[15:0]),
    .in_write_word     (in_tdata[47:16]),
    .in_reg_select     (in_tdata[50:48]),
    .stat              (stat),
    .read_data         (read_data),
    .pc_value          (pc_value),
    .halted            (halted),
    .executed_opcode   (executed_opcode),
    .reg_write_valid   (reg_write_valid),
    .reg_write_index   (reg_write_index),
    .reg_write_value   (reg_write_value),
    .mem_write_valid   (mem_write_valid),
    .mem_write_address (mem_write_address),
    .mem_write_value   (mem_write_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_data_r <= {7'd0, mem_write_value, mem_write_address, mem_write_valid,
                     reg_write_value, reg_write_index, reg_write_valid,
                     executed_opcode, halted, pc_value, read_data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/lc2k_datapath.sv
// Datapath: word memory, register file, pc, halt flag, ALU and result registers.
module lc2k_datapath import lc2k_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [15:0] in_word_address,
  input  logic [31:0] in_write_word,
  input  logic [2:0]  in_reg_select,
  output dp_stat_t    stat,
  output logic [31:0] read_data,
  output logic [15:0] pc_value,
  output logic        halted,
  output logic [2:0]  executed_opcode,
  output logic        reg_write_valid,
  output logic [2:0]  reg_write_index,
  output logic [31:0] reg_write_value,
  output logic        mem_write_valid,
  output logic [15:0] mem_write_address,
  output logic [31:0] mem_write_value
);

  logic [31:0]     mem_r [MEM_WORDS];
  logic [31:0]     mem_q_r;
  logic [MEM_AW:0] clr_cnt_r;

  logic [15:0] waddr_r;
  logic [31:0] wword_r;
  logic [2:0]  rsel_r;

  logic [15:0] pc_r;
  logic        halt_r;
  logic [31:0] rf_r [8];
  logic [31:0] ins_r;
  logic [31:0] va_r;
  logic [31:0] vb_r;

  logic [31:0] rdata_r;
  logic [2:0]  opc_r;
  logic        rw_v_r;
  logic [2:0]  rw_i_r;
  logic [31:0] rw_val_r;
  logic        mw_v_r;
  logic [15:0] mw_a_r;
  logic [31:0] mw_val_r;

  logic [MEM_AW-1:0] mem_addr;
  logic              mem_we;
  logic [31:0]       mem_wd;

  logic [2:0]  rfa_addr;
  logic [31:0] rfa_q;
  logic [31:0] rfb_q;

  logic [2:0]  opc;
  logic [2:0]  ra;
  logic [2:0]  rb;
  logic [15:0] off16;
  logic [31:0] off32;
  logic [15:0] pc_inc;
  logic [15:0] br_pc;
  logic [31:0] ls_sum;

  logic        rf_we;
  logic [2:0]  rf_wi;
  logic [31:0] rf_wd;

  // Instruction fields
  assign opc    = ins_r[24:22];
  assign ra     = ins_r[21:19];
  assign rb     = ins_r[18:16];
  assign off16  = ins_r[15:0];
  assign off32  = {{16{off16[15]}}, off16};
  assign pc_inc = pc_r + 16'd1;
  assign br_pc  = pc_inc + off16;
  assign ls_sum = vb_r + off32;

  // Single memory port, address chosen per operation
  always_comb begin
    case (cmd.mem_op)
      MOP_WR_IN, MOP_RD_IN: mem_addr = waddr_r[MEM_AW-1:0];
      MOP_FETCH:            mem_addr = pc_r[MEM_AW-1:0];
      MOP_RD_LS, MOP_WR_SW: mem_addr = ls_sum[MEM_AW-1:0];
      default:              mem_addr = clr_cnt_r[MEM_AW-1:0];
    endcase
    mem_we = cmd.clr_step || (cmd.mem_op == MOP_WR_IN) || (cmd.mem_op == MOP_WR_SW);
    if (cmd.clr_step) begin
      mem_wd = 32'd0;
    end else if (cmd.mem_op == MOP_WR_SW) begin
      mem_wd = va_r;
    end else begin
      mem_wd = wword_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem_r[mem_addr];
  end

  // Register file read ports: A serves regA at decode and register reads
  assign rfa_addr = cmd.decode ? mem_q_r[21:19] : rsel_r;
  assign rfa_q    = rf_r[rfa_addr];
  assign rfb_q    = rf_r[mem_q_r[18:16]];

  // Register file write port
  always_comb begin
    rf_we = 1'b0;
    rf_wi = ra;
    rf_wd = mem_q_r;
    if (cmd.exec) begin
      case (opc)
        OP_ADD: begin
          rf_we = 1'b1;
          rf_wi = off16[2:0];
          rf_wd = va_r + vb_r;
        end
        OP_NAND: begin
          rf_we = 1'b1;
          rf_wi = off16[2:0];
          rf_wd = ~(va_r & vb_r);
        end
        OP_JALR: begin
          rf_we = (ra != rb);
          rf_wi = ra;
          rf_wd = {16'd0, pc_inc};
        end
        default: rf_we = 1'b0;
      endcase
    end else if (cmd.load_wb) begin
      rf_we = 1'b1;
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      pc_r      <= 16'd0;
      halt_r    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= 32'd0;
      end
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.exec) begin
        if (opc == OP_HALT) begin
          halt_r <= 1'b1;
        end else if (opc == OP_BEQ) begin
          pc_r <= (va_r == vb_r) ? br_pc : pc_inc;
        end else if (opc == OP_JALR) begin
          pc_r <= (ra != rb) ? vb_r[15:0] : pc_inc;
        end else begin
          pc_r <= pc_inc;
        end
      end
      if (rf_we) begin
        rf_r[rf_wi] <= rf_wd;
      end
    end
  end

  // Request fields, operands and result fields
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      waddr_r  <= in_word_address;
      wword_r  <= in_write_word;
      rsel_r   <= in_reg_select;
      rdata_r  <= 32'd0;
      opc_r    <= OP_ADD;
      rw_v_r   <= 1'b0;
      rw_i_r   <= 3'd0;
      rw_val_r <= 32'd0;
      mw_v_r   <= 1'b0;
      mw_a_r   <= 16'd0;
      mw_val_r <= 32'd0;
    end
    if (cmd.decode) begin
      ins_r <= mem_q_r;
      va_r  <= rfa_q;
      vb_r  <= rfb_q;
    end
    if (cmd.cap_mem) begin
      rdata_r <= mem_q_r;
    end
    if (cmd.cap_reg) begin
      rdata_r <= rfa_q;
    end
    if (cmd.exec) begin
      opc_r <= opc;
      if (rf_we) begin
        rw_v_r   <= 1'b1;
        rw_i_r   <= rf_wi;
        rw_val_r <= rf_wd;
      end
      if (opc == OP_LW) begin
        rw_v_r <= 1'b1;
        rw_i_r <= ra;
      end
      if (opc == OP_SW) begin
        mw_v_r   <= 1'b1;
        mw_a_r   <= 16'(ls_sum[MEM_AW-1:0]);
        mw_val_r <= va_r;
      end
    end
    if (cmd.load_wb) begin
      rw_val_r <= mem_q_r;
    end
  end

  assign stat.clear_done = clr_cnt_r[MEM_AW];
  assign stat.halted     = halt_r;
  assign stat.opcode     = opc;

  assign read_data         = rdata_r;
  assign pc_value          = pc_r;
  assign halted            = halt_r;
  assign executed_opcode   = opc_r;
  assign reg_write_valid   = rw_v_r;
  assign reg_write_index   = rw_i_r;
  assign reg_write_value   = rw_val_r;
  assign mem_write_valid   = mw_v_r;
  assign mem_write_address = mw_a_r;
  assign mem_write_value   = mw_val_r;

endmodule

// File: sv/lc2k_ctrl.sv
// Controller: sequences memory clear, request commands and instruction steps.
module lc2k_ctrl import lc2k_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  logic [1:0] req_command,
  input  logic       out_free,
  input  dp_stat_t   stat,
  output logic       req_ready,
  output logic       deliver,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MEMWR  = 4'd2;
  localparam logic [3:0] S_MEMRD  = 4'd3;
  localparam logic [3:0] S_MEMCAP = 4'd4;
  localparam logic [3:0] S_REGRD  = 4'd5;
  localparam logic [3:0] S_FETCH  = 4'd6;
  localparam logic [3:0] S_DECODE = 4'd7;
  localparam logic [3:0] S_EXEC   = 4'd8;
  localparam logic [3:0] S_LOAD   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mem_op = MOP_NONE;
    req_ready = 1'b0;
    deliver   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take_in = 1'b1;
          case (req_command)
            CMD_MEM_WR: state_nxt = S_MEMWR;
            CMD_MEM_RD: state_nxt = S_MEMRD;
            CMD_REG_RD: state_nxt = S_REGRD;
            default:    state_nxt = stat.halted ? S_DONE : S_FETCH;
          endcase
        end
      end
      S_MEMWR: begin
        cmd.mem_op = MOP_WR_IN;
        state_nxt  = S_DONE;
      end
      S_MEMRD: begin
        cmd.mem_op = MOP_RD_IN;
        state_nxt  = S_MEMCAP;
      end
      S_MEMCAP: begin
        cmd.cap_mem = 1'b1;
        state_nxt   = S_DONE;
      end
      S_REGRD: begin
        cmd.cap_reg = 1'b1;
        state_nxt   = S_DONE;
      end
      S_FETCH: begin
        cmd.mem_op = MOP_FETCH;
        state_nxt  = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.opcode == OP_LW) begin
          cmd.mem_op = MOP_RD_LS;
          state_nxt  = S_LOAD;
        end else begin
          if (stat.opcode == OP_SW) begin
            cmd.mem_op = MOP_WR_SW;
          end
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        cmd.load_wb = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          deliver   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: test/tb_lc2k_instruction_executor.sv
// Testbench for lc2k_instruction_executor: directed and random requests checked against an ISA predictor.
module tb_lc2k_instruction_executor import lc2k_pkg::*;;

  localparam int CYCLE_LIMIT = 800000;  // must also cover the memory clear after reset
  localparam int DRAIN_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [31:0] read_data;
    logic [15:0] pc_value;
    logic        halted;
    logic [2:0]  opcode;
    logic        rw_valid;
    logic [2:0]  rw_index;
    logic [31:0] rw_value;
    logic        mw_valid;
    logic [15:0] mw_addr;
    logic [31:0] mw_value;
  } step_outcome_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // word_address, write_word, reg_select, pad
  logic [1:0]             in_tuser = '0;   // command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // read_data, pc_value, halted, executed_opcode,
                                           // reg_write_valid, reg_write_index, reg_write_value,
                                           // mem_write_valid, mem_write_address,
                                           // mem_write_value, pad

  // Predicted architectural state
  logic [15:0] cpu_pc = '0;
  logic        cpu_halted = 1'b0;
  logic [31:0] cpu_regs [8] = '{default: '0};
  logic [31:0] cpu_mem [int unsigned];
  int unsigned touched_addrs [$];

  step_outcome_t outcome_queue [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_ask = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int request_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int insn_count = 0;
  int store_count = 0;
  int jump_count = 0;

  lc2k_instruction_executor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] mem_word(logic [31:0] addr);
    int unsigned a;
    a = addr % MEM_WORDS;
    return cpu_mem.exists(a) ? cpu_mem[a] : 32'd0;
  endfunction

  function automatic void mem_store(logic [31:0] addr, logic [31:0] value);
    int unsigned a;
    a = addr % MEM_WORDS;
    cpu_mem[a] = value;
    touched_addrs.push_back(a);
    if (touched_addrs.size() > 64) void'(touched_addrs.pop_front());
  endfunction

  // Applies one request to the predicted state and returns the result it should produce
  function automatic step_outcome_t simulate_request(logic [1:0] cmd, logic [15:0] waddr,
      logic [31:0] wword, logic [2:0] rsel);
    step_outcome_t r;
    logic [31:0] ins, va, vb, off, ea;
    logic [2:0]  ra, rb;
    logic [15:0] nxt;
    r = '{default: '0};
    case (cmd)
      CMD_MEM_WR: mem_store({16'd0, waddr}, wword);
      CMD_MEM_RD: r.read_data = mem_word({16'd0, waddr});
      CMD_REG_RD: r.read_data = cpu_regs[rsel];
      CMD_EXEC: if (!cpu_halted) begin
        ins = mem_word({16'd0, cpu_pc});
        ra  = ins[21:19];
        rb  = ins[18:16];
        off = {{16{ins[15]}}, ins[15:0]};
        va  = cpu_regs[ra];
        vb  = cpu_regs[rb];
        ea  = vb + off;
        nxt = cpu_pc + 16'd1;
        r.opcode = ins[24:22];
        insn_count++;
        if (r.opcode == OP_HALT) begin
          cpu_halted = 1'b1;  // pc stays on the halt
        end else begin
          cpu_pc = nxt;
          case (r.opcode)
            OP_ADD, OP_NAND: begin
              r.rw_valid = 1'b1;
              r.rw_index = ins[2:0];  // destination from offset low bits
              r.rw_value = (r.opcode == OP_ADD) ? va + vb : ~(va & vb);
            end
            OP_LW: begin
              r.rw_valid = 1'b1;
              r.rw_index = ra;
              r.rw_value = mem_word(ea);
            end
            OP_SW: begin
              r.mw_valid = 1'b1;
              r.mw_addr  = 16'(ea % MEM_WORDS);
              r.mw_value = va;
              mem_store(ea, va);
              store_count++;
            end
            OP_BEQ: if (va == vb) begin
              cpu_pc = nxt + off[15:0];
              jump_count++;
            end
            OP_JALR: if (ra != rb) begin
              r.rw_valid = 1'b1;
              r.rw_index = ra;
              r.rw_value = {16'd0, nxt};
              cpu_pc = vb[15:0];
              jump_count++;
            end
            default: ;
          endcase
          if (r.rw_valid) cpu_regs[r.rw_index] = r.rw_value;
        end
      end
      default: ;
    endcase
    r.pc_value = cpu_pc;
    r.halted   = cpu_halted;
    return r;
  endfunction

  // Called at a rising edge; valid is left high after acceptance so back-to-back requests
  // never see two assignments in one step
  task automatic send_request(logic [1:0] cmd, logic [15:0] waddr, logic [31:0] wword,
      logic [2:0] rsel);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'd0, rsel, wword, waddr};
    do @(posedge clk); while (!in_tready);
    outcome_queue.push_back(simulate_request(cmd, waddr, wword, rsel));
    request_count++;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (outcome_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] make_instruction(logic [2:0] op, logic [2:0] ra,
      logic [2:0] rb, logic [15:0] off);
    return {7'($urandom), op, ra, rb, off};  // top bits are don't-care
  endfunction

  function automatic logic [15:0] pick_address();
    if (touched_addrs.size() == 0 || $urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'(touched_addrs[$urandom_range(0, touched_addrs.size() - 1)]);
  endfunction

  function automatic logic [31:0] data_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // Never halt here: the flag is sticky until reset
  function automatic logic [31:0] random_instruction();
    logic [2:0]  op, ra, rb;
    logic [15:0] off;
    op = 3'($urandom_range(0, 7));
    if (op == OP_HALT) op = OP_NOOP;
    ra = 3'($urandom);
    rb = 3'($urandom);
    case ($urandom_range(0, 2))
      0: off = 16'($urandom);
      1: off = 16'($urandom_range(0, 8)) - 16'd4;
      default: off = pick_address() - cpu_regs[rb][15:0];  // aim lw/sw at live data
    endcase
    return make_instruction(op, ra, rb, off);
  endfunction

  task automatic exec_instruction();
    logic [31:0] cur_ins;
    cur_ins = mem_word({16'd0, cpu_pc});
    if (cur_ins[24:22] == OP_HALT)
      send_request(CMD_MEM_WR, cpu_pc, random_instruction(), 3'($urandom));
    send_request(CMD_EXEC, 16'($urandom), $urandom, 3'($urandom));
  endtask

  task automatic step_program(logic [31:0] ins);
    send_request(CMD_MEM_WR, cpu_pc, ins, 3'($urandom));
    send_request(CMD_EXEC, 16'($urandom), $urandom, 3'($urandom));
  endtask

  task automatic run_program(int steps);
    repeat (steps) begin
      if ($urandom_range(0, 2) == 0)
        send_request(CMD_MEM_WR, pick_address(), data_word(), 3'($urandom));
      step_program(random_instruction());
      if ($urandom_range(0, 3) == 0)
        send_request(CMD_REG_RD, 16'($urandom), $urandom, 3'($urandom));
    end
  endtask

  task automatic random_noise();
    case ($urandom_range(0, 4))
      0: send_request(CMD_MEM_WR, 16'($urandom), data_word(), 3'($urandom));
      1: send_request(CMD_MEM_RD, pick_address(), $urandom, 3'($urandom));
      2: send_request(CMD_REG_RD, 16'($urandom), $urandom, 3'($urandom));
      default: repeat ($urandom_range(1, 4)) exec_instruction();  // run whatever is there
    endcase
  endtask

  task automatic test_directed_ops();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_request(CMD_MEM_WR, 16'hFFFF, 32'h8000_0000, 3'd7);
    send_request(CMD_MEM_WR, 16'hFFFE, 32'h7FFF_FFFF, 3'd0);
    send_request(CMD_MEM_RD, 16'h1234, 32'hFFFF_FFFF, 3'd7);  // never written
    send_request(CMD_REG_RD, 16'hFFFF, 32'd0, 3'd7);
    step_program(make_instruction(OP_LW, 3'd1, 3'd0, 16'hFFFF));    // negative offset
    step_program(make_instruction(OP_LW, 3'd2, 3'd0, 16'hFFFE));
    step_program(make_instruction(OP_ADD, 3'd1, 3'd1, 16'h8003));   // wraps to zero
    step_program(make_instruction(OP_NAND, 3'd3, 3'd2, 16'h0005));
    step_program(make_instruction(OP_SW, 3'd1, 3'd5, 16'h0002));    // address wraps past 2^32
    step_program(make_instruction(OP_BEQ, 3'd0, 3'd3, 16'h0010));   // taken
    step_program(make_instruction(OP_BEQ, 3'd1, 3'd2, 16'h0005));   // not taken
    step_program(make_instruction(OP_JALR, 3'd6, 3'd2, 16'h0000));  // jump to 0xFFFF
    step_program(make_instruction(OP_JALR, 3'd7, 3'd7, 16'h1234));  // equal regs, pc wraps
    step_program(make_instruction(OP_NOOP, 3'd5, 3'd6, 16'hFFFF));
    send_request(CMD_REG_RD, 16'd0, 32'd0, 3'd6);
    send_request(CMD_MEM_RD, 16'd1, 32'd0, 3'd0);
    wait_drained();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int n);
    int stop_at;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = request_count + n;
    while (request_count < stop_at) begin
      if ($urandom_range(0, 3) != 0) run_program($urandom_range(1, 6));
      else random_noise();
    end
    wait_drained();
  endtask

  // Receiver blocks for a long stretch while requests keep coming, so the input backs up
  task automatic test_result_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    @(negedge clk);
    hold_ask = HOLD_CYCLES;
    @(posedge clk);
    run_program(12);
    wait_drained();
  endtask

  task automatic test_halt_sticky();
    sender_idle_pct = 0;
    receiver_stall_pct = 30;
    step_program(make_instruction(OP_HALT, 3'd2, 3'd3, 16'h0001));
    send_request(CMD_EXEC, 16'($urandom), $urandom, 3'($urandom));  // ignored once halted
    send_request(CMD_MEM_WR, 16'h0042, 32'hDEAD_BEEF, 3'd0);
    send_request(CMD_MEM_RD, 16'h0042, 32'd0, 3'd0);
    send_request(CMD_REG_RD, 16'd0, 32'd0, 3'd1);
    send_request(CMD_EXEC, 16'($urandom), $urandom, 3'($urandom));
    wait_drained();
  endtask

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("MISMATCH result %0d %s: expected %h, got %h", result_count, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    step_outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("MISMATCH result %0d arrived with no request outstanding", result_count);
      end else begin
        want = outcome_queue.pop_front();
        check_field("read_data", out_tdata[31:0], want.read_data);
        check_field("pc_value", out_tdata[47:32], want.pc_value);
        check_field("halted", out_tdata[48], want.halted);
        check_field("executed_opcode", out_tdata[51:49], want.opcode);
        check_field("reg_write_valid", out_tdata[52], want.rw_valid);
        check_field("reg_write_index", out_tdata[55:53], want.rw_index);
        check_field("reg_write_value", out_tdata[87:56], want.rw_value);
        check_field("mem_write_valid", out_tdata[88], want.mw_valid);
        check_field("mem_write_address", out_tdata[104:89], want.mw_addr);
        check_field("mem_write_value", out_tdata[136:105], want.mw_value);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_count,
               outcome_queue.size());
      $display("lc2k_instruction_executor verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_random_traffic(0, 0, 300);
    test_random_traffic(63, 0, 300);
    test_random_traffic(0, 63, 300);
    test_random_traffic(15, 15, 300);
    test_result_backpressure();
    test_halt_sticky();
    if (outcome_queue.size() != 0) begin
      mismatch_count += outcome_queue.size();
      $display("%0d expected results never arrived", outcome_queue.size());
    end
    $display("Checked %0d results from %0d requests: %0d instructions run, %0d stores,",
             result_count, request_count, insn_count, store_count);
    $display("%0d taken branches or jumps, under four idle mixes, a long output stall and halt",
             jump_count);
    if (mismatch_count == 0)
      $display("lc2k_instruction_executor verification clean");
    else
      $display("lc2k_instruction_executor verification failed");
    $finish;
  end

endmodule
